// ===== hdl/mrg_pkg.sv =====
// Shared types and constants for the maze row generator.
// Used by mrg_ctrl, mrg_dpath and maze_row_generator_top; depends on nothing.
`default_nettype none

package mrg_pkg;

	localparam int COLS_DEF = 32;   // default column storage
	localparam int IO_W     = 32;   // width of the wall and random vectors
	localparam int IO_IDX_W = 5;    // bits to pick one bit of an IO_W vector
	localparam int CFG_W    = 6;    // active_cols register width
	localparam int COL_W    = 6;    // column counter, holds up to IO_W

	localparam logic [CFG_W-1:0] ACT_RST = 6'd32;

	// Column sweep being run by the datapath
	typedef enum logic [2:0] {
		PH_USED,
		PH_FRESH,
		PH_RIGHT,
		PH_BOTTOM,
		PH_FINAL
	} phase_t;

	typedef struct packed {
		logic             load;      // capture the input item
		logic             step;      // process column col in phase
		phase_t           phase;
		logic [COL_W-1:0] col;
		logic             out_load;  // move finished walls to the output register
	} mrg_cmd_t;

	typedef struct packed {
		logic last_col;   // col is the last active column
		logic last_row;   // item in work is the final row
		logic out_busy;   // output register still holds an untaken result
	} mrg_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mrg_ctrl.sv =====
// Sequencer for the maze row generator: walks the column sweeps of one row.
// Depends on mrg_pkg for the command and status structs.
`default_nettype none

module mrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrg_pkg::mrg_stat_t  stat,
	output mrg_pkg::mrg_cmd_t   cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_USED,
		S_FRESH,
		S_RIGHT,
		S_BOTTOM,
		S_FINAL,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic [mrg_pkg::COL_W-1:0]   col_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_ready & in_valid;
		cmd.col      = col_q;
		cmd.phase    = mrg_pkg::PH_USED;
		unique case (state_q)
			S_IDLE: begin
			end
			S_USED: begin
				cmd.step  = 1'b1;
				cmd.phase = mrg_pkg::PH_USED;
			end
			S_FRESH: begin
				cmd.step  = 1'b1;
				cmd.phase = mrg_pkg::PH_FRESH;
			end
			S_RIGHT: begin
				cmd.step  = 1'b1;
				cmd.phase = mrg_pkg::PH_RIGHT;
			end
			S_BOTTOM: begin
				cmd.step  = 1'b1;
				cmd.phase = mrg_pkg::PH_BOTTOM;
			end
			S_FINAL: begin
				cmd.step  = 1'b1;
				cmd.phase = mrg_pkg::PH_FINAL;
			end
			S_DONE: begin
				cmd.out_load = ~stat.out_busy;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_USED;
						col_q   <= '0;
					end
				end
				S_USED: begin
					if (stat.last_col) begin
						state_q <= S_FRESH;
						col_q   <= '0;
					end else begin
						col_q <= col_q + mrg_pkg::COL_W'(1);
					end
				end
				S_FRESH: begin
					if (stat.last_col) begin
						state_q <= S_RIGHT;
						col_q   <= '0;
					end else begin
						col_q <= col_q + mrg_pkg::COL_W'(1);
					end
				end
				S_RIGHT: begin
					if (stat.last_col) begin
						state_q <= stat.last_row ? S_FINAL : S_BOTTOM;
						col_q   <= '0;
					end else begin
						col_q <= col_q + mrg_pkg::COL_W'(1);
					end
				end
				S_BOTTOM, S_FINAL: begin
					if (stat.last_col) begin
						state_q <= S_DONE;
						col_q   <= '0;
					end else begin
						col_q <= col_q + mrg_pkg::COL_W'(1);
					end
				end
				S_DONE: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					col_q   <= '0;
				end
			endcase
		end
	end

	// a new row always starts its first sweep at column zero
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_USED) && (col_q == '0))
		else $error("row did not start at column zero");

	// the column counter never leaves the wall vector
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < mrg_pkg::COL_W'(mrg_pkg::IO_W))
		else $error("column counter out of range");

endmodule

`default_nettype wire

// ===== hdl/mrg_dpath.sv =====
// Datapath of the maze row generator: set labels, previous bottom walls,
// the per-column sweep logic and the output register. Depends on mrg_pkg.
`default_nettype none

module mrg_dpath #(
	parameter int COLS = mrg_pkg::COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mrg_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic [mrg_pkg::IO_W-1:0]      right_random,
	input  logic [mrg_pkg::IO_W-1:0]      down_random,
	input  logic                          first_row,
	input  logic                          last_row,
	input  mrg_pkg::mrg_cmd_t             cmd,
	output mrg_pkg::mrg_stat_t            stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [mrg_pkg::IO_W-1:0]      right_walls,
	output logic [mrg_pkg::IO_W-1:0]      bottom_walls
);

	localparam int LIM   = (COLS < mrg_pkg::IO_W) ? COLS : mrg_pkg::IO_W;
	localparam int IDX_W = $clog2(COLS);

	logic [mrg_pkg::CFG_W-1:0]  act_q;
	logic                       out_valid_q;

	logic [mrg_pkg::IO_W-1:0]   rr_q, dr_q, rw_q, bw_q, rwo_q, bwo_q;
	logic                       first_q, last_q;
	logic [mrg_pkg::COL_W-1:0]  n_q, n_cfg;
	logic [IDX_W-1:0]           lbl_q [COLS];
	logic [COLS-1:0]            bab_q;
	logic [COLS-1:0]            used_q;
	logic [IDX_W-1:0]           cur_q;

	logic [COLS-1:0]            inrng, bw_cols, match;
	logic [IDX_W-1:0]           col_idx, rd_idx, rd_lbl, left, free_lbl;
	logic [mrg_pkg::IO_IDX_W-1:0] bit_sel;
	logic                       fresh_c, rr_c, dr_c, same, other, wall, merge;

	// clamp the column count to 1..LIM
	always_comb begin
		if (act_q == '0) begin
			n_cfg = mrg_pkg::COL_W'(1);
		end else if (mrg_pkg::COL_W'(act_q) > mrg_pkg::COL_W'(LIM)) begin
			n_cfg = mrg_pkg::COL_W'(LIM);
		end else begin
			n_cfg = mrg_pkg::COL_W'(act_q);
		end
	end

	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			inrng[i] = mrg_pkg::COL_W'(i) < n_q;
		end
	end

	assign bw_cols = COLS'(bw_q);
	assign col_idx = IDX_W'(cmd.col);
	assign bit_sel = cmd.col[mrg_pkg::IO_IDX_W-1:0];

	// boundary sweeps look at column col+1, the others at col
	assign rd_idx = (cmd.phase == mrg_pkg::PH_RIGHT || cmd.phase == mrg_pkg::PH_FINAL)
		? IDX_W'(cmd.col + mrg_pkg::COL_W'(1)) : col_idx;
	assign rd_lbl = lbl_q[rd_idx];
	assign left   = (cmd.col == '0) ? lbl_q[0] : cur_q;
	assign same   = (left == rd_lbl);

	assign fresh_c = first_q | bab_q[col_idx];
	assign rr_c    = rr_q[bit_sel];
	assign dr_c    = dr_q[bit_sel];

	// lowest label no cell of the row holds yet
	always_comb begin
		free_lbl = '0;
		for (int i = COLS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_lbl = IDX_W'(i);
			end
		end
	end

	// another open cell of the same set exists
	always_comb begin
		for (int i = 0; i < COLS; i++) begin
			match[i] = inrng[i] && !bw_cols[i] && (lbl_q[i] == rd_lbl)
				&& (IDX_W'(i) != col_idx);
		end
		other = |match;
	end

	always_comb begin
		wall  = 1'b0;
		merge = 1'b0;
		unique case (cmd.phase)
			mrg_pkg::PH_RIGHT: begin
				wall  = rr_c | stat.last_col | same;
				merge = ~wall;
			end
			mrg_pkg::PH_FINAL: begin
				merge = ~stat.last_col & ~same;
			end
			default: begin
			end
		endcase
	end

	assign stat.last_col = (cmd.col + mrg_pkg::COL_W'(1)) == n_q;
	assign stat.last_row = last_q;
	assign stat.out_busy = out_valid_q & ~out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= mrg_pkg::ACT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				act_q <= cfg_wr_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rr_q    <= right_random;
			dr_q    <= down_random;
			first_q <= first_row;
			last_q  <= last_row;
			n_q     <= n_cfg;
			used_q  <= '0;
			rw_q    <= '0;
			bw_q    <= '0;
		end
		if (cmd.step) begin
			unique case (cmd.phase)
				mrg_pkg::PH_USED: begin
					if (!fresh_c) begin
						used_q[rd_lbl] <= 1'b1;
					end
				end
				mrg_pkg::PH_FRESH: begin
					if (fresh_c) begin
						lbl_q[col_idx]   <= free_lbl;
						used_q[free_lbl] <= 1'b1;
					end
				end
				mrg_pkg::PH_RIGHT: begin
					rw_q[bit_sel] <= wall;
				end
				mrg_pkg::PH_BOTTOM: begin
					if (dr_c && other) begin
						bw_q[bit_sel] <= 1'b1;
					end
				end
				mrg_pkg::PH_FINAL: begin
					bw_q[bit_sel] <= 1'b1;
					if (stat.last_col) begin
						rw_q[bit_sel] <= 1'b1;
					end else if (!same) begin
						rw_q[bit_sel] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			// merge: the right set takes the left set's label
			if (merge) begin
				for (int i = 0; i < COLS; i++) begin
					if (inrng[i] && lbl_q[i] == rd_lbl) begin
						lbl_q[i] <= left;
					end
				end
			end
			cur_q <= merge ? left : rd_lbl;
		end
		if (cmd.out_load) begin
			rwo_q <= rw_q;
			bwo_q <= bw_q;
			for (int i = 0; i < COLS; i++) begin
				if (inrng[i]) begin
					bab_q[i] <= bw_cols[i];
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign right_walls  = rwo_q;
	assign bottom_walls = bwo_q;

	// labels never run out: a row has no more cells than there are labels
	a_label_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && cmd.phase == mrg_pkg::PH_FRESH && fresh_c) |-> !(&used_q))
		else $error("no free set label");

	// the sequencer only steps through active columns
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (cmd.col < n_q))
		else $error("column step beyond active columns");

endmodule

`default_nettype wire

// ===== hdl/maze_row_generator_top.sv =====
// Top level of the maze row generator: sequencer plus datapath.
// Depends on mrg_pkg, mrg_ctrl and mrg_dpath.
`default_nettype none

// Maze row generator, one maze row per transfer. Each transfer on the input channel
// carries one random bit per column for right walls and one for bottom walls, plus the
// first-row and last-row flags. Each input transfer produces exactly one transfer on the
// output channel with the row's right and bottom wall vectors (bits at or above the active
// column count read as zero). Set labels and the previous row's bottom walls are kept
// between rows, so start every maze with first_row set; a row before any first row gives
// undefined walls.
// Operation: each row is worked in four column sweeps of one column per cycle through the
// shared label logic (collect inherited labels, hand out fresh labels, the right-wall pass,
// then the bottom-wall pass or the closing pass on the last row); the walls then move into
// the output register, where the result is offered. One item is in work at a time. The
// next is accepted the cycle after the result has moved to the output register, even if
// that result has not yet been taken. A result still waiting in the output register when
// the next row finishes holds the sequencer in its last state until it is taken.
// Write active_cols (1..32, reset 32) only while idle.
module maze_row_generator_top #(
	parameter int COLS = mrg_pkg::COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration: active column count
	input  logic                         cfg_wr_en,
	input  logic [mrg_pkg::CFG_W-1:0]    cfg_wr_data,
	// input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mrg_pkg::IO_W-1:0]     right_random,
	input  logic [mrg_pkg::IO_W-1:0]     down_random,
	input  logic                         first_row,
	input  logic                         last_row,
	// output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mrg_pkg::IO_W-1:0]     right_walls,
	output logic [mrg_pkg::IO_W-1:0]     bottom_walls
);

	mrg_pkg::mrg_cmd_t   cmd;
	mrg_pkg::mrg_stat_t  stat;

	// sequencer: advance one column per cycle, hold in the last state until
	// the output register is free
	mrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: labels, bottom walls of the row above, wall vectors
	mrg_dpath #(
		.COLS (COLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.right_random (right_random),
		.down_random  (down_random),
		.first_row    (first_row),
		.last_row     (last_row),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.right_walls  (right_walls),
		.bottom_walls (bottom_walls)
	);

endmodule

`default_nettype wire
